// File: rtl/button_gesture_detector_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the button gesture detector
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_DETECTOR_UNIT_ASSERT_SVH
`define BUTTON_GESTURE_DETECTOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define BGD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bgd check failed");

// antecedent implies consequent in the next cycle
`define BGD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bgd check failed");

`else

`define BGD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BGD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/bgd_pkg.sv
// ---------------------------------------------------------------------------
// Button gesture detector package
// Shared types, register indexes and constants.
// ---------------------------------------------------------------------------
package bgd_pkg;

    localparam int HOLD_W     = 16;
    localparam int DEB_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

    localparam logic [DEB_W-1:0]  DEB_RST  = 9'd50;
    localparam logic [HOLD_W-1:0] LONG_RST = 16'd2000;
    localparam logic [HOLD_W-1:0] DWIN_RST = 16'd300;
    localparam logic [HOLD_W-1:0] HELD_RST = 16'd3000;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HELD       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EVENTS_EN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 3'd5;

    typedef enum logic [2:0] {
        EV_PRESSED  = 3'd0,
        EV_RELEASED = 3'd1,
        EV_SHORT    = 3'd2,
        EV_LONG     = 3'd3,
        EV_DOUBLE   = 3'd4,
        EV_HELD     = 3'd5
    } t_ev_code;

    typedef struct packed {
        t_ev_code          code;
        logic [HOLD_W-1:0] hold;
        logic              last;
    } t_event;

    typedef struct packed {
        logic [DEB_W-1:0]  debounce_ticks;
        logic [HOLD_W-1:0] long_press_ticks;
        logic [HOLD_W-1:0] double_window_ticks;
        logic [HOLD_W-1:0] held_ticks;
        logic              events_enabled;
        logic              active_low;
    } t_cfg;

    // events produced by one tick
    typedef struct packed {
        logic [1:0] num;
        t_event     ev0;
        t_event     ev1;
    } t_tick_out;

endpackage

// File: rtl/bgd_cfg.sv
// ---------------------------------------------------------------------------
// Configuration registers
// Six registers written by index; unknown indexes are dropped.
// ---------------------------------------------------------------------------
module bgd_cfg
    import bgd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (i_index)
                CFG_DEBOUNCE:   n_cfg.debounce_ticks      = i_data[DEB_W-1:0];
                CFG_LONG_PRESS: n_cfg.long_press_ticks    = i_data[HOLD_W-1:0];
                CFG_DOUBLE_WIN: n_cfg.double_window_ticks = i_data[HOLD_W-1:0];
                CFG_HELD:       n_cfg.held_ticks          = i_data[HOLD_W-1:0];
                CFG_EVENTS_EN:  n_cfg.events_enabled      = i_data[0];
                CFG_ACTIVE_LOW: n_cfg.active_low          = i_data[0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks      <= DEB_RST;
            r_cfg.long_press_ticks    <= LONG_RST;
            r_cfg.double_window_ticks <= DWIN_RST;
            r_cfg.held_ticks          <= HELD_RST;
            r_cfg.events_enabled      <= 1'b1;
            r_cfg.active_low          <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/bgd_core.sv
// ---------------------------------------------------------------------------
// Gesture state update
// Debounce, hold timing and gesture decisions for one tick per cycle while i_go is high.
// ---------------------------------------------------------------------------
`include "button_gesture_detector_unit_assert.svh"

module bgd_core
    import bgd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_go,
    input  logic      i_pin,
    input  t_cfg      i_cfg,
    output t_tick_out o_out
);

    localparam int NSLOT = 7;

    logic              r_prev, n_prev;
    logic [DEB_W-1:0]  r_dcnt, n_dcnt;
    logic              r_darm, n_darm;
    logic              r_down, n_down;
    logic [HOLD_W-1:0] r_hold, n_hold;
    logic              r_larm, n_larm;
    logic              r_harm, n_harm;
    logic [1:0]        r_presses, n_presses;
    logic [HOLD_W-1:0] r_since, n_since;
    logic [HOLD_W-1:0] r_stmr, n_stmr;
    logic              r_sarm, n_sarm;
    logic [HOLD_W-1:0] r_saved, n_saved;

    logic              settle, pressed;
    logic [HOLD_W-1:0] rel_hold;
    logic [HOLD_W-1:0] long_min, held_min;
    logic [NSLOT-1:0]  slot_v;
    t_ev_code          slot_c [NSLOT];
    logic [HOLD_W-1:0] slot_h [NSLOT];
    logic [1:0]        sel_n;
    t_event            sel_ev0, sel_ev1;

    assign long_min = (i_cfg.long_press_ticks == '0) ? HOLD_W'(1) : i_cfg.long_press_ticks;
    assign held_min = (i_cfg.held_ticks == '0) ? HOLD_W'(1) : i_cfg.held_ticks;
    assign pressed  = i_cfg.active_low ? ~i_pin : i_pin;

    always_comb begin
        n_prev    = r_prev;
        n_dcnt    = r_dcnt;
        n_darm    = r_darm;
        n_down    = r_down;
        n_hold    = r_hold;
        n_larm    = r_larm;
        n_harm    = r_harm;
        n_presses = r_presses;
        n_since   = r_since;
        n_stmr    = r_stmr;
        n_sarm    = r_sarm;
        n_saved   = r_saved;
        settle    = 1'b0;
        rel_hold  = '0;
        slot_v    = '0;

        // time advances
        if (r_down && r_hold != HOLD_MAX) n_hold = r_hold + HOLD_W'(1);
        if (r_since != HOLD_MAX) n_since = r_since + HOLD_W'(1);
        if (r_sarm && r_stmr != '0) n_stmr = r_stmr - HOLD_W'(1);

        // debounce
        if (i_pin != r_prev) begin
            n_prev = i_pin;
            n_darm = 1'b1;
            n_dcnt = (i_cfg.debounce_ticks == '0) ? DEB_W'(1) : i_cfg.debounce_ticks;
        end else if (r_darm) begin
            if (r_dcnt <= DEB_W'(1)) begin
                n_darm = 1'b0;
                n_dcnt = '0;
                settle = 1'b1;
            end else begin
                n_dcnt = r_dcnt - DEB_W'(1);
            end
        end

        if (settle && pressed && !r_down) begin
            n_down    = 1'b1;
            n_hold    = '0;
            if (r_presses != 2'd3) n_presses = r_presses + 2'd1;
            slot_v[0] = 1'b1;
            n_sarm    = 1'b0;
            n_larm    = 1'b1;
            n_harm    = 1'b1;
        end else if (settle && !pressed && r_down) begin
            rel_hold  = n_hold;
            n_down    = 1'b0;
            n_larm    = 1'b0;
            n_harm    = 1'b0;
            slot_v[1] = 1'b1;
            if (n_hold >= i_cfg.held_ticks) begin
                // reported already as held
                n_saved = r_saved;
            end else if (n_hold >= i_cfg.long_press_ticks) begin
                slot_v[2] = 1'b1;
                n_presses = '0;
            end else if (r_presses >= 2'd2 && n_since < i_cfg.double_window_ticks) begin
                slot_v[3] = 1'b1;
                n_presses = '0;
            end else begin
                n_stmr  = i_cfg.double_window_ticks;
                n_sarm  = 1'b1;
                n_saved = n_hold;
            end
            n_since = '0;
        end

        if (n_down && n_larm && n_hold >= long_min) begin
            n_larm    = 1'b0;
            slot_v[4] = 1'b1;
            n_presses = '0;
        end

        if (n_down && n_harm && n_hold >= held_min) begin
            n_harm    = 1'b0;
            slot_v[5] = 1'b1;
        end

        if (n_sarm && n_stmr == '0) begin
            n_sarm = 1'b0;
            if (n_presses == 2'd1 && !n_down) begin
                slot_v[6] = 1'b1;
                n_presses = '0;
            end
        end
    end

    always_comb begin
        slot_c[0] = EV_PRESSED;  slot_h[0] = '0;
        slot_c[1] = EV_RELEASED; slot_h[1] = rel_hold;
        slot_c[2] = EV_LONG;     slot_h[2] = rel_hold;
        slot_c[3] = EV_DOUBLE;   slot_h[3] = rel_hold;
        slot_c[4] = EV_LONG;     slot_h[4] = n_hold;
        slot_c[5] = EV_HELD;     slot_h[5] = n_hold;
        slot_c[6] = EV_SHORT;    slot_h[6] = n_saved;
    end

    // keep the first two events in tick order
    always_comb begin
        sel_n   = '0;
        sel_ev0 = '{code: EV_PRESSED, hold: '0, last: 1'b0};
        sel_ev1 = '{code: EV_PRESSED, hold: '0, last: 1'b1};
        for (int i = 0; i < NSLOT; i++) begin
            if (slot_v[i] && i_cfg.events_enabled) begin
                if (sel_n == 2'd0) begin
                    sel_ev0.code = slot_c[i];
                    sel_ev0.hold = slot_h[i];
                end else if (sel_n == 2'd1) begin
                    sel_ev1.code = slot_c[i];
                    sel_ev1.hold = slot_h[i];
                end
                if (sel_n != 2'd2) sel_n = sel_n + 2'd1;
            end
        end
        sel_ev0.last = (sel_n == 2'd1);
    end

    always_comb begin
        o_out.num = i_go ? sel_n : 2'd0;
        o_out.ev0 = sel_ev0;
        o_out.ev1 = sel_ev1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= 1'b1;
            r_dcnt    <= '0;
            r_darm    <= 1'b0;
            r_down    <= 1'b0;
            r_hold    <= '0;
            r_larm    <= 1'b0;
            r_harm    <= 1'b0;
            r_presses <= '0;
            r_since   <= HOLD_MAX;
            r_stmr    <= '0;
            r_sarm    <= 1'b0;
            r_saved   <= '0;
        end else if (i_go) begin
            r_prev    <= n_prev;
            r_dcnt    <= n_dcnt;
            r_darm    <= n_darm;
            r_down    <= n_down;
            r_hold    <= n_hold;
            r_larm    <= n_larm;
            r_harm    <= n_harm;
            r_presses <= n_presses;
            r_since   <= n_since;
            r_stmr    <= n_stmr;
            r_sarm    <= n_sarm;
            r_saved   <= n_saved;
        end
    end

    // a press always cancels the pending short press
    `BGD_ASSERT_IMP(a_down_no_short, i_clk, i_rst_n, r_down, !r_sarm)

endmodule

// File: rtl/bgd_fifo.sv
// ---------------------------------------------------------------------------
// Result queue
// Takes up to two events per cycle, hands out one beat per cycle unless the sink stalls.
// ---------------------------------------------------------------------------
`include "button_gesture_detector_unit_assert.svh"

module bgd_fifo
    import bgd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_n,
    input  t_event     i_ev0,
    input  t_event     i_ev1,
    output logic       o_room,
    output logic       o_valid,
    input  logic       i_stall,
    output t_event     o_ev
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    // pointer advance that wraps at DEPTH, power of two or not
    function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] ptr,
                                                  input logic [1:0]       step);
        logic [PTR_W:0] sum;
        sum = {1'b0, ptr} + (PTR_W+1)'(step);
        if (sum >= (PTR_W+1)'(DEPTH)) sum = sum - (PTR_W+1)'(DEPTH);
        return sum[PTR_W-1:0];
    endfunction

    t_event             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [PTR_W-1:0]   wr_next;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               pop;

    assign pop     = o_valid && !i_stall;
    assign n_wr    = ptr_step(r_wr, i_push_n);
    assign n_rd    = ptr_step(r_rd, {1'b0, pop});
    assign wr_next = ptr_step(r_wr, 2'd1);
    assign n_count = r_count + COUNT_W'(i_push_n) - COUNT_W'(pop);

    // room for a full tick whatever the sink does
    assign o_room  = r_count <= COUNT_W'(DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_ev    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) r_mem[r_wr] <= i_ev0;
        if (i_push_n == 2'd2) r_mem[wr_next] <= i_ev1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `BGD_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= COUNT_W'(DEPTH))
    `BGD_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push_n != 2'd0,
                    32'(r_count) + 32'(i_push_n) <= 32'(DEPTH) + 32'(pop))
    `BGD_ASSERT_NXT(a_pop_only, i_clk, i_rst_n, pop && i_push_n == 2'd0, r_count == $past(r_count) - COUNT_W'(1))

endmodule

// File: rtl/button_gesture_detector_unit.sv
// ---------------------------------------------------------------------------
// Button gesture detector
// Debounced button events: pressed, released, short, long, double, held.
// ---------------------------------------------------------------------------
// One raw pin sample per tick enters on the input channel; a tick is taken
// every clock cycle while the result queue has room for two events. A tick
// passes from the input register into the result queue, whose head drives
// the output. The output port moves one event beat per cycle unless the sink
// stalls; a tick with two events leaves as two beats. Input keeps one tick per
// cycle while ticks average at most one event. Configure only while idle.
module button_gesture_detector_unit
    import bgd_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_pin_level,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [2:0]            o_event_code,
    output logic [HOLD_W-1:0]     o_hold_ticks,
    output logic                  o_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      cfg;
    t_tick_out tick;
    t_event    q_ev;
    logic      room, go, in_acc;
    logic      r_pvld, n_pvld;
    logic      r_pin;

    assign o_cfg_ready = 1'b1;

    bgd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // input register
    assign go      = r_pvld && room;
    assign o_stall = r_pvld && !room;
    assign in_acc  = i_valid && !o_stall;
    assign n_pvld  = in_acc ? 1'b1 : (go ? 1'b0 : r_pvld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pvld <= 1'b0;
        else          r_pvld <= n_pvld;
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) r_pin <= i_pin_level;
    end

    bgd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_pin   (r_pin),
        .i_cfg   (cfg),
        .o_out   (tick)
    );

    bgd_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (tick.num),
        .i_ev0    (tick.ev0),
        .i_ev1    (tick.ev1),
        .o_room   (room),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_ev     (q_ev)
    );

    assign o_event_code = q_ev.code;
    assign o_hold_ticks = q_ev.hold;
    assign o_last       = q_ev.last;

endmodule
